/* rtl/ddrc_pkg.sv */
// ----------------------------------------------------------------------------
// ddrc_pkg
// Shared widths, reset values and register indexes of the arcade drive mixer.
// ----------------------------------------------------------------------------
package ddrc_pkg;

	localparam int WIDTH_BITS_DEF = 12;
	localparam int SPEED_BITS_DEF = 8;

	localparam int ELEV_MID_RST  = 1450;
	localparam int RUDD_MID_RST  = 1450;
	localparam int FULL_DEFL_RST = 300;
	localparam int DEADBAND_RST  = 20;
	localparam int SPEED_LIM_RST = 255;
	localparam int FWD_POL_RST   = 1;

	localparam int CFG_IDX_BITS = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_ELEV_MID  = 3'd0,
		CFG_RUDD_MID  = 3'd1,
		CFG_FULL_DEFL = 3'd2,
		CFG_DEADBAND  = 3'd3,
		CFG_SPEED_LIM = 3'd4,
		CFG_FWD_POL   = 3'd5
	} cfg_reg_t;

endpackage

/* rtl/differential_drive_rc_mixer_top.sv */
// ----------------------------------------------------------------------------
// differential_drive_rc_mixer_top
// Arcade drive mixer: centers elevator and rudder widths, mixes them into
// right and left motor speed and direction, and derives the gear switch.
// ----------------------------------------------------------------------------
// The block takes one input beat at a time. From the accepting edge it works
// through the states PREP, ABS, MUL, SAT, DIV and DONE, and takes a new beat
// only once it is back in IDLE. The length of that run comes from the
// scaling datapath: a bit-serial shift-add multiply by speed_limit and a
// restoring divide by full_deflection, each retiring one bit per cycle, with
// both motor sides worked in parallel lanes. A finished result sits in the
// output register, so the next input beat is taken while it waits for out_ready.
// Configuration writes take effect at once and are meant to be made while idle.
module differential_drive_rc_mixer_top
	import ddrc_pkg::*;
#(
	parameter int WIDTH_BITS = WIDTH_BITS_DEF,
	parameter int SPEED_BITS = SPEED_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,

	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [WIDTH_BITS-1:0]   elev_width,
	input  logic [WIDTH_BITS-1:0]   rudd_width,
	input  logic [WIDTH_BITS-1:0]   gear_width,
	input  logic                    update_enable,

	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [SPEED_BITS-1:0]   right_speed,
	output logic [SPEED_BITS-1:0]   left_speed,
	output logic                    right_dir,
	output logic                    left_dir,
	output logic                    gear_switch,

	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [(WIDTH_BITS > SPEED_BITS ? WIDTH_BITS : SPEED_BITS)-1:0] cfg_data
);

	localparam int W  = WIDTH_BITS;
	localparam int S  = SPEED_BITS;
	localparam int MW = W + 2;          // signed mixed value
	localparam int PW = W + 1 + S;      // magnitude times limit
	localparam int CW = $clog2(S);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_ABS,
		ST_MUL,
		ST_SAT,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t state_q;
	logic [CW-1:0] cnt_q;

	// configuration
	logic [W-1:0] em_q, rm_q, fd_q, db_q;
	logic [S-1:0] lim_q;
	logic         pol_q;

	// captured input beat
	logic [W-1:0] e_q, r_q, g_q;
	logic         en_q;

	// lanes: 0 right, 1 left
	logic signed [MW-1:0] m_q     [2];
	logic        [W:0]    mag_q   [2];
	logic                 dir_q   [2];
	logic                 zero_q  [2];
	logic        [PW-1:0] acc_q   [2];
	logic                 sat_q   [2];
	logic        [W-1:0]  rem_q   [2];
	logic        [S-1:0]  low_q   [2];
	logic        [S-1:0]  quo_q   [2];
	logic        [S-1:0]  lim_sh_q;
	logic                 gsw_q;

	// held motor outputs
	logic [S-1:0] held_spd_q [2];
	logic         held_dir_q [2];

	logic [S-1:0] rs_q, ls_q;
	logic         rd_q, ld_q, gs_q, ov_q;

	// combinational datapath
	logic signed [MW-1:0] ele_d, rud_d;
	logic signed [MW-1:0] neg_m [2];
	logic        [W:0]    abs_d [2];
	logic                 big_d [2];
	logic        [PW-1:0] acc_nx [2];
	logic        [W:0]    r2_d  [2];
	logic                 ge_d  [2];
	logic        [W:0]    dif_d [2];
	logic        [S-1:0]  spd_d [2];
	logic                 load_out;

	assign ele_d = $signed({2'b00, e_q}) - $signed({2'b00, em_q});
	assign rud_d = $signed({2'b00, r_q}) - $signed({2'b00, rm_q});

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			neg_m[i]  = -m_q[i];
			abs_d[i]  = m_q[i][MW-1] ? neg_m[i][W:0] : m_q[i][W:0];
			big_d[i]  = abs_d[i] > {1'b0, db_q};
			acc_nx[i] = {acc_q[i][PW-2:0], 1'b0}
				+ (lim_sh_q[S-1] ? PW'(mag_q[i]) : '0);
			// restoring divide: shift in the next dividend bit
			r2_d[i]   = {rem_q[i], low_q[i][S-1]};
			ge_d[i]   = r2_d[i] >= {1'b0, fd_q};
			dif_d[i]  = r2_d[i] - {1'b0, fd_q};
			if (zero_q[i]) begin
				spd_d[i] = '0;
			end else if (sat_q[i] || (quo_q[i] > lim_q)) begin
				spd_d[i] = lim_q;
			end else begin
				spd_d[i] = quo_q[i];
			end
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign load_out = (state_q == ST_DONE) && (!ov_q || out_ready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_q  <= W'(ELEV_MID_RST);
			rm_q  <= W'(RUDD_MID_RST);
			fd_q  <= W'(FULL_DEFL_RST);
			db_q  <= W'(DEADBAND_RST);
			lim_q <= S'(SPEED_LIM_RST);
			pol_q <= 1'(FWD_POL_RST);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_ELEV_MID:  em_q  <= cfg_data[W-1:0];
				CFG_RUDD_MID:  rm_q  <= cfg_data[W-1:0];
				CFG_FULL_DEFL: fd_q  <= cfg_data[W-1:0];
				CFG_DEADBAND:  db_q  <= cfg_data[W-1:0];
				CFG_SPEED_LIM: lim_q <= cfg_data[S-1:0];
				CFG_FWD_POL:   pol_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer, held state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
			rs_q    <= '0;
			ls_q    <= '0;
			rd_q    <= 1'b0;
			ld_q    <= 1'b0;
			gs_q    <= 1'b0;
			for (int i = 0; i < 2; i++) begin
				held_spd_q[i] <= '0;
				held_dir_q[i] <= 1'b0;
			end
		end else begin
			if (ov_q && out_ready && !load_out) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: state_q <= ST_ABS;
				ST_ABS: begin
					cnt_q   <= CW'(S - 1);
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_SAT;
					end
				end
				ST_SAT: begin
					cnt_q   <= CW'(S - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						if (en_q) begin
							for (int i = 0; i < 2; i++) begin
								held_spd_q[i] <= spd_d[i];
								held_dir_q[i] <= dir_q[i];
							end
							rs_q <= spd_d[0];
							ls_q <= spd_d[1];
							rd_q <= dir_q[0];
							ld_q <= dir_q[1];
						end else begin
							rs_q <= held_spd_q[0];
							ls_q <= held_spd_q[1];
							rd_q <= held_dir_q[0];
							ld_q <= held_dir_q[1];
						end
						gs_q    <= gsw_q;
						ov_q    <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			e_q  <= elev_width;
			r_q  <= rudd_width;
			g_q  <= gear_width;
			en_q <= update_enable;
		end
		case (state_q)
			ST_PREP: begin
				m_q[0]   <= ele_d + rud_d;
				m_q[1]   <= ele_d - rud_d;
				gsw_q    <= g_q > em_q;
				lim_sh_q <= lim_q;
			end
			ST_ABS: begin
				for (int i = 0; i < 2; i++) begin
					// inside the deadband: zero speed, forward
					mag_q[i]  <= big_d[i] ? abs_d[i] : '0;
					zero_q[i] <= !big_d[i] || (abs_d[i] == '0);
					dir_q[i]  <= (big_d[i] && m_q[i][MW-1]) ? !pol_q : pol_q;
					acc_q[i]  <= '0;
				end
			end
			ST_MUL: begin
				for (int i = 0; i < 2; i++) begin
					acc_q[i] <= acc_nx[i];
				end
				lim_sh_q <= {lim_sh_q[S-2:0], 1'b0};
			end
			ST_SAT: begin
				for (int i = 0; i < 2; i++) begin
					// quotient of S+1 bits or more always saturates
					sat_q[i] <= acc_q[i][PW-1:S] >= {1'b0, fd_q};
					rem_q[i] <= acc_q[i][S+W-1:S];
					low_q[i] <= acc_q[i][S-1:0];
					quo_q[i] <= '0;
				end
			end
			ST_DIV: begin
				for (int i = 0; i < 2; i++) begin
					rem_q[i] <= ge_d[i] ? dif_d[i][W-1:0] : r2_d[i][W-1:0];
					low_q[i] <= {low_q[i][S-2:0], 1'b0};
					quo_q[i] <= {quo_q[i][S-2:0], ge_d[i]};
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = ov_q;
	assign right_speed = rs_q;
	assign left_speed  = ls_q;
	assign right_dir   = rd_q;
	assign left_dir    = ld_q;
	assign gear_switch = gs_q;

endmodule

/* rtl/ddrc_checker.sv */
// ----------------------------------------------------------------------------
// ddrc_checker
// Port-level checks of the arcade drive mixer, bound to its top level.
// ----------------------------------------------------------------------------
module ddrc_checker
	import ddrc_pkg::*;
#(
	parameter int SPEED_BITS = SPEED_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [SPEED_BITS-1:0] right_speed,
	input logic [SPEED_BITS-1:0] left_speed,
	input logic                  right_dir,
	input logic                  left_dir,
	input logic                  gear_switch
);

	// a stalled result beat keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(right_speed)
			&& $stable(left_speed) && $stable(right_dir) && $stable(left_dir)
			&& $stable(gear_switch))
		else $error("result beat changed while stalled");

	// one item in flight: no input beat right after another
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in flight");

	// a result never shows up the cycle after its input beat
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result appeared too early");

	// the block is free again when a new result appears
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> in_ready)
		else $error("result appeared while busy");

endmodule

bind differential_drive_rc_mixer_top ddrc_checker #(
	.SPEED_BITS(SPEED_BITS)
) u_ddrc_checker (.*);
